// File: rtl/tcq_pkg.sv
package tcq_pkg;

  localparam int unsigned StampW = 64;
  localparam int unsigned SourceW = 8;
  localparam int unsigned RunW = 32;
  localparam int unsigned MinRunW = 16;
  localparam int unsigned EventW = 4;
  localparam int unsigned RegIndexW = 3;

  localparam logic [RunW-1:0] RUN_MAX = '1;
  localparam logic [MinRunW-1:0] MIN_RUN_FLOOR = MinRunW'(2);
  localparam logic [StampW-1:0] SEQ_STEP = StampW'(2);

  localparam logic CMD_OBSERVE = 1'b0;
  localparam logic CMD_INVALIDATE = 1'b1;

  typedef enum logic [EventW-1:0] {
    EV_CONTINUE      = 4'd0,
    EV_START         = 4'd1,
    EV_SOURCE_CHANGE = 4'd2,
    EV_DUPLICATE     = 4'd3,
    EV_BACKWARD      = 4'd4,
    EV_JUMP          = 4'd5,
    EV_HOST_STALL    = 4'd6,
    EV_ZERO_STAMP    = 4'd7,
    EV_ZERO_HOST     = 4'd8,
    EV_BAD_SOURCE    = 4'd9,
    EV_INVALIDATE    = 4'd10
  } event_t;

  typedef enum logic [RegIndexW-1:0] {
    REG_MAX_STEP      = 3'd0,
    REG_MIN_READY_RUN = 3'd1,
    REG_UNCERTAINTY   = 3'd2,
    REG_EPOCH_ID      = 3'd3,
    REG_PTP_CODE      = 3'd4,
    REG_GPS_CODE      = 3'd5,
    REG_UNKNOWN_CODE  = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic               command;
    logic [StampW-1:0]  sensor_stamp;
    logic [StampW-1:0]  host_time;
    logic [SourceW-1:0] source_code;
    logic [StampW-1:0]  update_time;
  } sample_t;

  typedef struct packed {
    logic               ready_res;
    logic [EventW-1:0]  event_res;
    logic [StampW-1:0]  anchor_stamp;
    logic [StampW-1:0]  anchor_host_time;
    logic [StampW-1:0]  anchor_update_time;
    logic [SourceW-1:0] anchor_source;
    logic [StampW-1:0]  anchor_uncertainty;
    logic [RunW-1:0]    run_length;
    logic [StampW-1:0]  publish_sequence;
  } record_t;

  typedef struct packed {
    logic [RegIndexW-1:0] index;
    logic [StampW-1:0]    value;
  } cfg_write_t;

  typedef struct packed {
    logic [StampW-1:0]  prev_stamp;
    logic [StampW-1:0]  prev_host_time;
    logic [SourceW-1:0] prev_source;
    logic [RunW-1:0]    run_count;
  } cont_state_t;

  typedef struct packed {
    logic [StampW-1:0]  max_step;
    logic [MinRunW-1:0] min_ready_run;
    logic [StampW-1:0]  uncertainty;
    logic [SourceW-1:0] ptp_code;
    logic [SourceW-1:0] gps_code;
    logic [SourceW-1:0] unknown_code;
  } qual_cfg_t;

endpackage

// File: rtl/tcq_chan_if.sv
interface tcq_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: rtl/tcq_check.sv
module tcq_check (
  input  tcq_pkg::sample_t     item,
  input  tcq_pkg::cont_state_t st,
  input  tcq_pkg::qual_cfg_t   qc,
  input  logic [tcq_pkg::StampW-1:0] seq,
  output tcq_pkg::cont_state_t st_next,
  output tcq_pkg::record_t     rec
);
  import tcq_pkg::*;

  event_t             reject_ev;
  logic               reject;
  event_t             cont_ev;
  logic [StampW-1:0]  step_lim;
  logic [StampW-1:0]  step;
  logic [MinRunW-1:0] min_run;
  logic [RunW-1:0]    run_next;
  logic [StampW-1:0]  unc_eff;

  always_comb begin
    reject = 1'b1;
    reject_ev = EV_INVALIDATE;
    if (item.command == CMD_INVALIDATE) begin
      reject_ev = EV_INVALIDATE;
    end else if (item.sensor_stamp == '0) begin
      reject_ev = EV_ZERO_STAMP;
    end else if (item.host_time == '0) begin
      reject_ev = EV_ZERO_HOST;
    end else if (item.source_code != qc.ptp_code && item.source_code != qc.gps_code) begin
      reject_ev = EV_BAD_SOURCE;
    end else begin
      reject = 1'b0;
    end
  end

  assign step_lim = (qc.max_step == '0) ? StampW'(1) : qc.max_step;
  assign step = item.sensor_stamp - st.prev_stamp;
  assign min_run = (qc.min_ready_run < MIN_RUN_FLOOR) ? MIN_RUN_FLOOR : qc.min_ready_run;
  assign unc_eff = (qc.uncertainty == '0) ? StampW'(1) : qc.uncertainty;

  // first break found wins
  always_comb begin
    if (st.run_count == '0) begin
      cont_ev = EV_START;
    end else if (item.source_code != st.prev_source) begin
      cont_ev = EV_SOURCE_CHANGE;
    end else if (item.sensor_stamp == st.prev_stamp) begin
      cont_ev = EV_DUPLICATE;
    end else if (item.sensor_stamp < st.prev_stamp) begin
      cont_ev = EV_BACKWARD;
    end else if (step > step_lim) begin
      cont_ev = EV_JUMP;
    end else if (item.host_time <= st.prev_host_time) begin
      cont_ev = EV_HOST_STALL;
    end else begin
      cont_ev = EV_CONTINUE;
    end
  end

  always_comb begin
    if (cont_ev != EV_CONTINUE) begin
      run_next = RunW'(1);
    end else if (st.run_count == RUN_MAX) begin
      run_next = RUN_MAX;
    end else begin
      run_next = st.run_count + RunW'(1);
    end
  end

  always_comb begin
    rec.anchor_update_time = item.update_time;
    rec.anchor_uncertainty = unc_eff;
    rec.publish_sequence = seq;
    if (reject) begin
      st_next.prev_stamp = '0;
      st_next.prev_host_time = '0;
      st_next.prev_source = qc.unknown_code;
      st_next.run_count = '0;
      rec.ready_res = 1'b0;
      rec.event_res = reject_ev;
      rec.anchor_stamp = '0;
      rec.anchor_host_time = '0;
      rec.anchor_source = qc.unknown_code;
      rec.run_length = '0;
    end else begin
      st_next.prev_stamp = item.sensor_stamp;
      st_next.prev_host_time = item.host_time;
      st_next.prev_source = item.source_code;
      st_next.run_count = run_next;
      rec.ready_res = (run_next >= {{(RunW-MinRunW){1'b0}}, min_run});
      rec.event_res = cont_ev;
      rec.anchor_stamp = item.sensor_stamp;
      rec.anchor_host_time = item.host_time;
      rec.anchor_source = item.source_code;
      rec.run_length = run_next;
    end
  end

endmodule

// File: rtl/timestamp_continuity_qualifier.sv
// A request accepted into the input register has its record registered in the result register.
// Throughput: one request per cycle while result is not back-pressured; the continuity
// state is read and rewritten by one compare/subtract pass in the result stage per request.
// Reset (rst, synchronous): clears continuity state and sequence counter,
// restores register defaults and empties both stages.
module timestamp_continuity_qualifier (
  input logic clk,
  input logic rst,
  tcq_chan_if.sink   cfg,
  tcq_chan_if.sink   sample,
  tcq_chan_if.source result
);
  import tcq_pkg::*;

  qual_cfg_t qc;
  logic [StampW-1:0] epoch_id;

  logic        s1_valid;
  sample_t     s1_item;
  cont_state_t st;
  cont_state_t st_next;
  logic [StampW-1:0] seq;
  logic [StampW-1:0] seq_next;
  logic        out_valid;
  record_t     out_rec;
  record_t     rec_next;
  logic        advance;
  cfg_write_t  cw;

  assign cw = cfg.data;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      qc.max_step <= StampW'(1);
      qc.min_ready_run <= MinRunW'(2);
      qc.uncertainty <= StampW'(1);
      epoch_id <= StampW'(1);
      qc.ptp_code <= SourceW'(1);
      qc.gps_code <= SourceW'(2);
      qc.unknown_code <= '0;
    end else if (cfg.valid) begin
      unique case (cw.index)
        REG_MAX_STEP:      qc.max_step <= cw.value;
        REG_MIN_READY_RUN: qc.min_ready_run <= cw.value[MinRunW-1:0];
        REG_UNCERTAINTY:   qc.uncertainty <= cw.value;
        REG_EPOCH_ID:      epoch_id <= cw.value;
        REG_PTP_CODE:      qc.ptp_code <= cw.value[SourceW-1:0];
        REG_GPS_CODE:      qc.gps_code <= cw.value[SourceW-1:0];
        REG_UNKNOWN_CODE:  qc.unknown_code <= cw.value[SourceW-1:0];
        default: ;
      endcase
    end
  end

  assign advance = !out_valid || result.ready;
  assign sample.ready = !s1_valid || advance;
  assign seq_next = seq + SEQ_STEP;

  tcq_check u_check (
    .item    (s1_item),
    .st      (st),
    .qc      (qc),
    .seq     (seq_next),
    .st_next (st_next),
    .rec     (rec_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.valid && sample.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (sample.valid && sample.ready) begin
      s1_item <= sample.data;
    end
  end

  // result register and continuity state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      seq <= '0;
      st.prev_stamp <= '0;
      st.prev_host_time <= '0;
      st.prev_source <= '0;
      st.run_count <= '0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        seq <= seq_next;
        st <= st_next;
      end
    end
    if (advance && s1_valid) begin
      out_rec <= rec_next;
    end
  end

  assign result.valid = out_valid;
  assign result.data = out_rec;

`ifndef SYNTH
  a_seq_even: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !out_rec.publish_sequence[0])
    else $error("odd publish sequence");

  a_reject_empty: assert property (@(posedge clk) disable iff (rst)
    result.valid && (out_rec.event_res == EV_ZERO_STAMP ||
      out_rec.event_res == EV_ZERO_HOST || out_rec.event_res == EV_BAD_SOURCE ||
      out_rec.event_res == EV_INVALIDATE)
    |-> out_rec.run_length == '0 && !out_rec.ready_res && out_rec.anchor_stamp == '0)
    else $error("rejected record not empty");

  a_break_restart: assert property (@(posedge clk) disable iff (rst)
    result.valid && out_rec.event_res != EV_CONTINUE && out_rec.event_res != EV_ZERO_STAMP &&
      out_rec.event_res != EV_ZERO_HOST && out_rec.event_res != EV_BAD_SOURCE &&
      out_rec.event_res != EV_INVALIDATE
    |-> out_rec.run_length == RunW'(1))
    else $error("break did not restart run");

  a_ready_min: assert property (@(posedge clk) disable iff (rst)
    result.valid && out_rec.ready_res |-> out_rec.run_length >= RunW'(2))
    else $error("ready below minimum run");

  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    advance && s1_valid |=> seq == $past(seq) + SEQ_STEP)
    else $error("sequence did not advance by two");
`endif

endmodule
